FILE: design/irfan_pkg.sv
// Package with types, codes and constants of the IR remote fan phase controller.
`default_nettype none
package irfan_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [1:0] ACT_PULSE = 2'd0;
    localparam logic [1:0] ACT_ZERO_CROSS = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    localparam logic [2:0] REG_LEADER_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_BIT_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_DELAY_LEVEL_0 = 3'd2;
    localparam logic [2:0] REG_DELAY_LEVEL_1 = 3'd3;
    localparam logic [2:0] REG_DELAY_LEVEL_2 = 3'd4;
    localparam logic [2:0] REG_DELAY_LEVEL_3 = 3'd5;
    localparam logic [2:0] REG_DELAY_LEVEL_4 = 3'd6;

    localparam logic [15:0] LEADER_THRESHOLD_RST = 16'd2500;
    localparam logic [15:0] BIT_THRESHOLD_RST = 16'd500;
    localparam logic [7:0] DELAY_LEVEL_0_RST = 8'd180;
    localparam logic [7:0] DELAY_LEVEL_1_RST = 8'd130;
    localparam logic [7:0] DELAY_LEVEL_2_RST = 8'd90;
    localparam logic [7:0] DELAY_LEVEL_3_RST = 8'd50;
    localparam logic [7:0] DELAY_LEVEL_4_RST = 8'd10;

    localparam logic [7:0] FIRE_TICKS = 8'd10;
    localparam logic [5:0] FRAME_BITS = 6'd32;
    localparam logic [5:0] FIRST_KEPT_BIT = 6'd17;

    localparam logic [15:0] KEY_SPEED_0 = 16'd59678;
    localparam logic [15:0] KEY_SPEED_1 = 16'd62228;
    localparam logic [15:0] KEY_SPEED_2 = 16'd59168;
    localparam logic [15:0] KEY_SPEED_3 = 16'd41318;
    localparam logic [15:0] KEY_SPEED_4 = 16'd63248;
    localparam logic [15:0] KEY_LAMP_ONE_ON = 16'd58148;
    localparam logic [15:0] KEY_LAMP_ONE_OFF = 16'd42338;
    localparam logic [15:0] KEY_LAMP_TWO_ON = 16'd48458;
    localparam logic [15:0] KEY_LAMP_TWO_OFF = 16'd44378;

    localparam logic [2:0] SPEED_MAX = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DELAY = 2'd1,
        PH_FIRE = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0] action;
        logic pulse_level;
        logic [15:0] pulse_length;
    } in_item_t;

    typedef struct packed {
        logic gate_drive;
        logic lamp_one;
        logic lamp_two;
        logic [2:0] speed_level;
        logic frame_done;
        logic [15:0] frame_key;
    } out_item_t;

endpackage
`default_nettype wire

FILE: design/ir_remote_fan_phase_controller.sv
// IR remote frame decoder with TRIAC phase-angle gate control and a two-entry result queue.
//
// Channel  | Direction | Handshake             | Payload
// in       | input     | in_valid / in_ready   | in_data (in_item_t)
// out      | output    | out_valid / out_ready | out_data (out_item_t)
// config   | input     | APB psel / penable    | paddr, pwdata, prdata
//
// Each item's state update and result are computed in one pass, and the result is
// written into a two-entry output queue at the accepting edge.
// A result appears on out_data in the cycle after its item is accepted if no earlier result stays queued.
// in_ready falls only when both queue entries hold results that have not been taken.
// Reset is asynchronous and active low; it clears all state and restores register defaults.
`default_nettype none
module ir_remote_fan_phase_controller
    import irfan_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_ready,
    input wire in_item_t in_data,
    output logic out_valid,
    input wire logic out_ready,
    output out_item_t out_data,
    input wire logic psel,
    input wire logic penable,
    input wire logic pwrite,
    input wire logic [ADDR_W-1:0] paddr,
    input wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic pready
);

    logic [15:0] leader_threshold_reg;
    logic [15:0] bit_threshold_reg;
    logic [7:0] delay_level_0_reg;
    logic [7:0] delay_level_1_reg;
    logic [7:0] delay_level_2_reg;
    logic [7:0] delay_level_3_reg;
    logic [7:0] delay_level_4_reg;

    logic collecting_reg;
    logic collecting_next;
    logic [5:0] bit_count_reg;
    logic [5:0] bit_count_next;
    logic [15:0] key_shift_reg;
    logic [15:0] key_shift_next;
    logic [2:0] speed_index_reg;
    logic [2:0] speed_index_next;
    logic [1:0] lamp_state_reg;
    logic [1:0] lamp_state_next;
    phase_t fire_phase_reg;
    phase_t fire_phase_next;
    logic [7:0] fire_counter_reg;
    logic [7:0] fire_counter_next;

    out_item_t head_reg;
    logic head_valid_reg;
    out_item_t tail_reg;
    logic tail_valid_reg;

    logic push;
    logic pop;
    logic cfg_write;
    logic [2:0] reg_index;
    logic [5:0] count_inc;
    logic [5:0] kept_offset;
    logic [7:0] delay_sel;
    logic [7:0] counter_dec;
    logic frame_done;
    logic [15:0] frame_key;
    out_item_t result;

    assign pready = 1'b1;
    assign reg_index = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign in_ready = !tail_valid_reg;
    assign push = in_valid && in_ready;
    assign pop = head_valid_reg && out_ready;
    assign out_valid = head_valid_reg;
    assign out_data = head_reg;

    always_comb
    begin
        case (reg_index)
            REG_LEADER_THRESHOLD: prdata = {{(DATA_W-16){1'b0}}, leader_threshold_reg};
            REG_BIT_THRESHOLD: prdata = {{(DATA_W-16){1'b0}}, bit_threshold_reg};
            REG_DELAY_LEVEL_0: prdata = {{(DATA_W-8){1'b0}}, delay_level_0_reg};
            REG_DELAY_LEVEL_1: prdata = {{(DATA_W-8){1'b0}}, delay_level_1_reg};
            REG_DELAY_LEVEL_2: prdata = {{(DATA_W-8){1'b0}}, delay_level_2_reg};
            REG_DELAY_LEVEL_3: prdata = {{(DATA_W-8){1'b0}}, delay_level_3_reg};
            REG_DELAY_LEVEL_4: prdata = {{(DATA_W-8){1'b0}}, delay_level_4_reg};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leader_threshold_reg <= LEADER_THRESHOLD_RST;
            bit_threshold_reg <= BIT_THRESHOLD_RST;
            delay_level_0_reg <= DELAY_LEVEL_0_RST;
            delay_level_1_reg <= DELAY_LEVEL_1_RST;
            delay_level_2_reg <= DELAY_LEVEL_2_RST;
            delay_level_3_reg <= DELAY_LEVEL_3_RST;
            delay_level_4_reg <= DELAY_LEVEL_4_RST;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_LEADER_THRESHOLD: leader_threshold_reg <= pwdata[15:0];
                REG_BIT_THRESHOLD: bit_threshold_reg <= pwdata[15:0];
                REG_DELAY_LEVEL_0: delay_level_0_reg <= pwdata[7:0];
                REG_DELAY_LEVEL_1: delay_level_1_reg <= pwdata[7:0];
                REG_DELAY_LEVEL_2: delay_level_2_reg <= pwdata[7:0];
                REG_DELAY_LEVEL_3: delay_level_3_reg <= pwdata[7:0];
                REG_DELAY_LEVEL_4: delay_level_4_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (speed_index_reg)
            3'd0: delay_sel = delay_level_0_reg;
            3'd1: delay_sel = delay_level_1_reg;
            3'd2: delay_sel = delay_level_2_reg;
            3'd3: delay_sel = delay_level_3_reg;
            default: delay_sel = delay_level_4_reg;
        endcase
    end

    assign count_inc = bit_count_reg + 6'd1;
    assign kept_offset = count_inc - FIRST_KEPT_BIT;
    assign counter_dec = (fire_counter_reg != 8'd0) ? fire_counter_reg - 8'd1 : 8'd0;

    always_comb
    begin
        collecting_next = collecting_reg;
        bit_count_next = bit_count_reg;
        key_shift_next = key_shift_reg;
        speed_index_next = speed_index_reg;
        lamp_state_next = lamp_state_reg;
        fire_phase_next = fire_phase_reg;
        fire_counter_next = fire_counter_reg;
        frame_done = 1'b0;
        frame_key = 16'd0;
        case (in_data.action)
            ACT_PULSE:
            begin
                if (!collecting_reg)
                begin
                    if (!in_data.pulse_level && in_data.pulse_length > leader_threshold_reg)
                    begin
                        collecting_next = 1'b1;
                        bit_count_next = 6'd0;
                        key_shift_next = 16'd0;
                    end
                end
                else if (in_data.pulse_level)
                begin
                    bit_count_next = count_inc;
                    if (count_inc >= FIRST_KEPT_BIT && count_inc <= FRAME_BITS
                        && in_data.pulse_length > bit_threshold_reg)
                    begin
                        key_shift_next[kept_offset[3:0]] = 1'b1;
                    end
                    if (count_inc >= FRAME_BITS)
                    begin
                        collecting_next = 1'b0;
                        frame_done = 1'b1;
                        frame_key = key_shift_next;
                        bit_count_next = 6'd0;
                        case (key_shift_next)
                            KEY_SPEED_0: speed_index_next = 3'd0;
                            KEY_SPEED_1: speed_index_next = 3'd1;
                            KEY_SPEED_2: speed_index_next = 3'd2;
                            KEY_SPEED_3: speed_index_next = 3'd3;
                            KEY_SPEED_4: speed_index_next = 3'd4;
                            KEY_LAMP_ONE_ON: lamp_state_next[0] = 1'b1;
                            KEY_LAMP_ONE_OFF: lamp_state_next[0] = 1'b0;
                            KEY_LAMP_TWO_ON: lamp_state_next[1] = 1'b1;
                            KEY_LAMP_TWO_OFF: lamp_state_next[1] = 1'b0;
                            default: ;
                        endcase
                    end
                end
            end
            ACT_ZERO_CROSS:
            begin
                if (fire_phase_reg == PH_IDLE)
                begin
                    if (delay_sel == 8'd0)
                    begin
                        fire_phase_next = PH_FIRE;
                        fire_counter_next = FIRE_TICKS;
                    end
                    else
                    begin
                        fire_phase_next = PH_DELAY;
                        fire_counter_next = delay_sel;
                    end
                end
            end
            ACT_TICK:
            begin
                case (fire_phase_reg)
                    PH_DELAY:
                    begin
                        if (counter_dec == 8'd0)
                        begin
                            fire_phase_next = PH_FIRE;
                            fire_counter_next = FIRE_TICKS;
                        end
                        else
                        begin
                            fire_counter_next = counter_dec;
                        end
                    end
                    PH_FIRE:
                    begin
                        fire_counter_next = counter_dec;
                        if (counter_dec == 8'd0)
                        begin
                            fire_phase_next = PH_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb
    begin
        result.gate_drive = (fire_phase_next == PH_FIRE);
        result.lamp_one = lamp_state_next[0];
        result.lamp_two = lamp_state_next[1];
        result.speed_level = speed_index_next;
        result.frame_done = frame_done;
        result.frame_key = frame_key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            bit_count_reg <= 6'd0;
            key_shift_reg <= 16'd0;
            speed_index_reg <= 3'd0;
            lamp_state_reg <= 2'd0;
            fire_phase_reg <= PH_IDLE;
            fire_counter_reg <= 8'd0;
        end
        else if (push)
        begin
            collecting_reg <= collecting_next;
            bit_count_reg <= bit_count_next;
            key_shift_reg <= key_shift_next;
            speed_index_reg <= speed_index_next;
            lamp_state_reg <= lamp_state_next;
            fire_phase_reg <= fire_phase_next;
            fire_counter_reg <= fire_counter_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (tail_valid_reg)
            begin
                head_valid_reg <= 1'b1;
                tail_valid_reg <= push;
            end
            else
            begin
                head_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_valid_reg <= 1'b1;
            end
            else
            begin
                tail_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (tail_valid_reg)
            begin
                head_reg <= tail_reg;
                if (push)
                begin
                    tail_reg <= result;
                end
            end
            else if (push)
            begin
                head_reg <= result;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_reg <= result;
            end
            else
            begin
                tail_reg <= result;
            end
        end
    end

`ifndef ASSERT_OFF
    a_tail_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        tail_valid_reg |-> head_valid_reg)
        else $error("Second queue entry is valid while the first is empty.");

    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !collecting_reg |-> (bit_count_reg == 6'd0))
        else $error("Bit count is nonzero outside a frame.");

    a_count_below_frame: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg < FRAME_BITS)
        else $error("Bit count reached the frame length without closing the frame.");

    a_fire_counter_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fire_phase_reg == PH_FIRE) |-> (fire_counter_reg != 8'd0
            && fire_counter_reg <= FIRE_TICKS))
        else $error("Gate pulse counter is out of range while firing.");

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        speed_index_reg <= SPEED_MAX)
        else $error("Speed index is beyond the last level.");
`endif

endmodule
`default_nettype wire
